[rtl/dnv_pkg.sv]
// shared types and constants for the decimal number text validator
`timescale 1ns / 1ps

package dnv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_EXP_LO  = 8'h65;
    localparam logic [CHAR_W-1:0] CH_EXP_UP  = 8'h45;

    typedef struct packed {
        logic is_point;
        logic is_minus;
        logic is_plus;
        logic is_digit;
        logic is_exp;
    } t_char_class;

endpackage

[rtl/dnv_char_class.sv]
// character classifier: decodes one ascii code into class flags
`timescale 1ns / 1ps

module dnv_char_class
    import dnv_pkg::*;
(
    input  logic [CHAR_W-1:0] i_char_code,
    output t_char_class       o_class
);

    always_comb begin
        o_class.is_point = (i_char_code == CH_POINT);
        o_class.is_minus = (i_char_code == CH_MINUS);
        o_class.is_plus  = (i_char_code == CH_PLUS);
        o_class.is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        o_class.is_exp   = (i_char_code == CH_EXP_LO) || (i_char_code == CH_EXP_UP);
    end

endmodule

[rtl/dnv_token_check.sv]
// per-token state and verdict logic
`timescale 1ns / 1ps

module dnv_token_check
    import dnv_pkg::*;
#(
    parameter int unsigned MAX_LEN = 300
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_char_class i_class,
    input  logic        i_is_last,
    output logic        o_tok_ok
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_point, n_point;
    logic               r_expect, n_expect;
    logic               r_failed, n_failed;

    logic               first;
    logic               too_long;
    logic               char_bad;
    logic               fail_all;

    always_comb begin
        first    = (r_count == '0);
        too_long = (({1'b0, r_count} + (COUNT_W+1)'(1)) >= (COUNT_W+1)'(MAX_LEN));
        char_bad = 1'b0;
        n_point  = r_point;
        n_expect = r_expect;

        if (r_expect) begin
            n_expect = 1'b0;
            char_bad = !(i_class.is_plus || i_class.is_minus) || i_is_last;
        end else if (i_class.is_point) begin
            char_bad = r_point || i_is_last;
            n_point  = 1'b1;
        end else if (first && i_class.is_minus) begin
            char_bad = i_is_last;
        end else if (i_class.is_digit) begin
            char_bad = 1'b0;
        end else if (i_class.is_exp) begin
            char_bad = first || i_is_last;
            n_expect = 1'b1;
        end else begin
            char_bad = 1'b1;
        end

        fail_all = r_failed || too_long || char_bad;
        o_tok_ok = !fail_all;

        n_failed = fail_all;
        n_count  = (r_count == COUNT_SAT) ? r_count : r_count + COUNT_W'(1);

        // verdict given, start the next token clean
        if (i_is_last) begin
            n_count  = '0;
            n_point  = 1'b0;
            n_expect = 1'b0;
            n_failed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_point  <= 1'b0;
            r_expect <= 1'b0;
            r_failed <= 1'b0;
        end else if (i_step) begin
            r_count  <= n_count;
            r_point  <= n_point;
            r_expect <= n_expect;
            r_failed <= n_failed;
        end
    end

endmodule

[rtl/decimal_number_text_validator_top.sv]
// Decimal number text validator top level.
// A last character's verdict is registered from the input register into the result register.
// Throughput: one character per cycle unless a last character waits for the result slot;
// the input and result registers admit a new transaction while a verdict waits downstream.
// Reset: synchronous active-low i_rst_n clears the token state and both valid flags.
`timescale 1ns / 1ps

module decimal_number_text_validator_top
    import dnv_pkg::*;
#(
    parameter int unsigned MAX_LEN = 300
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_is_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_is_valid
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_out_valid;
    logic              r_out_ok;

    t_char_class       char_cls;
    logic              tok_ok;
    logic              out_free;
    logic              advance;

    // non-last characters need no result slot
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !r_last);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
            r_last <= i_is_last;
        end
    end

    dnv_char_class u_class (
        .i_char_code (r_char),
        .o_class     (char_cls)
    );

    dnv_token_check #(
        .MAX_LEN (MAX_LEN)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_class   (char_cls),
        .i_is_last (r_last),
        .o_tok_ok  (tok_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out_ok <= tok_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_valid  = r_out_ok;

endmodule
